### hw/rtl/assert_macros.svh
// Assertion macros for the SHA-256 hasher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked by clk and disabled while rst_n is low.
`define SHA_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Same, with the clock and the active-low reset named explicitly.
`define SHA_ASSERT_CLK(lbl, ck, rn, prop, msg) \
    lbl: assert property (@(posedge ck) disable iff (!rn) prop) else $error(msg);
`else
`define SHA_ASSERT(lbl, prop, msg)
`define SHA_ASSERT_CLK(lbl, ck, rn, prop, msg)
`endif
`endif

### hw/rtl/sha256_pkg.sv
// Types, constants and round functions of the SHA-256 hasher.
package sha256_pkg;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_ROUND,
        S_FINAL,
        S_OUT
    } sha_state_t;

    localparam logic [7:0] PAD_MARKER = 8'h80;
    localparam logic [5:0] LEN_POS    = 6'd56;
    localparam logic [63:0] BITS_PER_BYTE = 64'd8;

    localparam logic [31:0] HASH_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'b0, x[31:10]};
    endfunction

endpackage

### hw/rtl/sha256_message_hasher_top.sv
// SHA-256 message hasher: byte input, padding, round engine and digest output.
// The message arrives one byte per word on the msg channel, with byte_present
// saying whether the byte counts and end_of_message closing the message (an
// empty message is allowed). A byte is taken whenever msg_stall is low while the
// 64-byte block fills. Each full block then runs through a single round unit at
// one round per cycle, followed by a fold of the result into the chaining value
// (S_FINAL), and msg_stall stays high during that time. At end of message the
// padding bytes are generated one per cycle between compressions (up to 64, or
// up to 72 when an extra block is needed) with a compression after each full
// block, and then the eight digest words go out on the dig channel, word 0
// first. After the last word is taken the block is ready for the next message.
`include "assert_macros.svh"

module sha256_message_hasher_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        msg_valid,
    output logic        msg_stall,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        end_of_message,
    output logic        dig_valid,
    input  logic        dig_stall,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    sha256_pkg::sha_state_t state_reg, state_next;
    sha256_pkg::sha_state_t ret_reg, ret_next;

    logic [31:0] chain_reg [8];
    logic [31:0] chain_next [8];
    logic [31:0] work_reg [8];
    logic [31:0] work_next [8];
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [23:0] acc_reg, acc_next;
    logic [63:0] bit_count_reg, bit_count_next;
    logic [5:0]  byte_pos_reg, byte_pos_next;
    logic [5:0]  round_reg, round_next;
    logic        marker_reg, marker_next;
    logic        len_phase_reg, len_phase_next;
    logic [2:0]  len_idx_reg, len_idx_next;
    logic [2:0]  out_idx_reg, out_idx_next;

    logic        msg_accept;
    logic        dig_accept;
    logic        push_en;
    logic [7:0]  push_byte;
    logic [7:0]  pad_byte;
    logic        len_now;
    logic        last_len;
    logic        block_done;
    logic [7:0]  len_bytes [8];
    logic [31:0] sched_word;
    logic [31:0] t1;
    logic [31:0] t2;

    assign msg_accept = msg_valid && !msg_stall;
    assign dig_accept = dig_valid && !dig_stall;

    // The length goes out most significant byte first.
    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            len_bytes[i] = bit_count_reg[63 - 8 * i -: 8];
        end
    end

    // The length field starts once the marker is in and the block reaches byte 56.
    assign len_now  = len_phase_reg || (marker_reg && (byte_pos_reg == sha256_pkg::LEN_POS));
    assign last_len = len_now && (len_idx_reg == 3'd7);

    always_comb
    begin
        priority if (!marker_reg)
        begin
            pad_byte = sha256_pkg::PAD_MARKER;
        end
        else if (len_now)
        begin
            pad_byte = len_bytes[len_idx_reg];
        end
        else
        begin
            pad_byte = 8'h00;
        end
    end

    assign push_en    = (state_reg == sha256_pkg::S_PAD)
                        || ((state_reg == sha256_pkg::S_IDLE) && msg_accept && byte_present);
    assign push_byte  = (state_reg == sha256_pkg::S_PAD) ? pad_byte : data_byte;
    assign block_done = push_en && (&byte_pos_reg);

    // Round unit: the window always holds W[t..t+15], so W[t+16] comes from fixed taps.
    assign sched_word = sha256_pkg::small_sigma1(win_reg[14]) + win_reg[9]
                        + sha256_pkg::small_sigma0(win_reg[1]) + win_reg[0];
    assign t1 = work_reg[7] + sha256_pkg::big_sigma1(work_reg[4])
                + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
                + sha256_pkg::ROUND_K[round_reg] + win_reg[0];
    assign t2 = sha256_pkg::big_sigma0(work_reg[0])
                + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
                   ^ (work_reg[1] & work_reg[2]));

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        unique case (state_reg)
            sha256_pkg::S_IDLE:
            begin
                if (msg_accept)
                begin
                    if (block_done)
                    begin
                        state_next = sha256_pkg::S_ROUND;
                        ret_next   = end_of_message ? sha256_pkg::S_PAD : sha256_pkg::S_IDLE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = sha256_pkg::S_PAD;
                    end
                end
            end
            sha256_pkg::S_PAD:
            begin
                if (block_done)
                begin
                    state_next = sha256_pkg::S_ROUND;
                    ret_next   = last_len ? sha256_pkg::S_OUT : sha256_pkg::S_PAD;
                end
            end
            sha256_pkg::S_ROUND:
            begin
                if (&round_reg)
                begin
                    state_next = sha256_pkg::S_FINAL;
                end
            end
            sha256_pkg::S_FINAL:
            begin
                state_next = ret_reg;
            end
            sha256_pkg::S_OUT:
            begin
                if (dig_accept && last_word)
                begin
                    state_next = sha256_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = sha256_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb
    begin
        msg_stall   = (state_reg != sha256_pkg::S_IDLE);
        dig_valid   = (state_reg == sha256_pkg::S_OUT);
        digest_word = chain_reg[out_idx_reg];
        word_index  = out_idx_reg;
        last_word   = (out_idx_reg == 3'd7);
    end

    // Datapath.
    always_comb
    begin
        chain_next     = chain_reg;
        work_next      = work_reg;
        win_next       = win_reg;
        acc_next       = acc_reg;
        bit_count_next = bit_count_reg;
        byte_pos_next  = byte_pos_reg;
        round_next     = round_reg;
        marker_next    = marker_reg;
        len_phase_next = len_phase_reg;
        len_idx_next   = len_idx_reg;
        out_idx_next   = out_idx_reg;

        if (push_en)
        begin
            byte_pos_next = byte_pos_reg + 6'd1;
            if (&byte_pos_reg[1:0])
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = {acc_reg, push_byte};
            end
            else
            begin
                acc_next = {acc_reg[15:0], push_byte};
            end
            if (block_done)
            begin
                work_next  = chain_reg;
                round_next = 6'd0;
            end
        end

        unique case (state_reg)
            sha256_pkg::S_IDLE:
            begin
                if (msg_accept)
                begin
                    if (byte_present)
                    begin
                        bit_count_next = bit_count_reg + sha256_pkg::BITS_PER_BYTE;
                    end
                    if (end_of_message)
                    begin
                        marker_next    = 1'b0;
                        len_phase_next = 1'b0;
                        len_idx_next   = 3'd0;
                    end
                end
            end
            sha256_pkg::S_PAD:
            begin
                marker_next = 1'b1;
                if (len_now)
                begin
                    len_phase_next = 1'b1;
                    len_idx_next   = len_idx_reg + 3'd1;
                end
            end
            sha256_pkg::S_ROUND:
            begin
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = sched_word;
                work_next[7] = work_reg[6];
                work_next[6] = work_reg[5];
                work_next[5] = work_reg[4];
                work_next[4] = work_reg[3] + t1;
                work_next[3] = work_reg[2];
                work_next[2] = work_reg[1];
                work_next[1] = work_reg[0];
                work_next[0] = t1 + t2;
                round_next   = round_reg + 6'd1;
            end
            sha256_pkg::S_FINAL:
            begin
                for (int i = 0; i < 8; i++)
                begin
                    chain_next[i] = chain_reg[i] + work_reg[i];
                end
            end
            sha256_pkg::S_OUT:
            begin
                if (dig_accept)
                begin
                    out_idx_next = out_idx_reg + 3'd1;
                    if (last_word)
                    begin
                        chain_next     = sha256_pkg::HASH_INIT;
                        bit_count_next = 64'd0;
                    end
                end
            end
            default:
            begin
                out_idx_next = 3'd0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha256_pkg::S_IDLE;
            ret_reg       <= sha256_pkg::S_IDLE;
            chain_reg     <= sha256_pkg::HASH_INIT;
            for (int i = 0; i < 8; i++)
            begin
                work_reg[i] <= 32'd0;
            end
            bit_count_reg <= 64'd0;
            byte_pos_reg  <= 6'd0;
            round_reg     <= 6'd0;
            marker_reg    <= 1'b0;
            len_phase_reg <= 1'b0;
            len_idx_reg   <= 3'd0;
            out_idx_reg   <= 3'd0;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            chain_reg     <= chain_next;
            work_reg      <= work_next;
            bit_count_reg <= bit_count_next;
            byte_pos_reg  <= byte_pos_next;
            round_reg     <= round_next;
            marker_reg    <= marker_next;
            len_phase_reg <= len_phase_next;
            len_idx_reg   <= len_idx_next;
            out_idx_reg   <= out_idx_next;
        end
    end

    // Message window and byte packing carry data only.
    always_ff @(posedge clk)
    begin
        win_reg <= win_next;
        acc_reg <= acc_next;
    end

    `SHA_ASSERT(a_round_only_in_round, (round_reg != 6'd0) |-> (state_reg == sha256_pkg::S_ROUND), "round counter busy outside round state")
    `SHA_ASSERT(a_round_then_final, (state_reg == sha256_pkg::S_ROUND && round_reg == 6'd63) |=> (state_reg == sha256_pkg::S_FINAL), "last round not followed by fold")
    `SHA_ASSERT(a_digest_block_aligned, $rose(dig_valid) |-> (byte_pos_reg == 6'd0 && len_phase_reg), "digest started off a block boundary")
    `SHA_ASSERT(a_len_after_marker, (len_idx_reg != 3'd0) |-> marker_reg, "length bytes before the pad marker")
    `SHA_ASSERT_CLK(a_restart_clean, clk, rst_n, (dig_accept && last_word) |=> (chain_reg[0] == sha256_pkg::HASH_INIT[0] && bit_count_reg == 64'd0), "state not restored after digest")

endmodule
